>>> rtl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants
// Field widths, register indexes and the records passed between the
// temperature front end, the queue and the pressure back end.
// ----------------------------------------------------------------------------
package bsc_pkg;

   localparam int RAW_W     = 20;
   localparam int CENTI_W   = 24;
   localparam int FINE_W    = 32;
   localparam int PRES_W    = 32;
   localparam int CAL_W     = 48;
   localparam int CSR_IDX_W = 8;
   localparam int WIDE_W    = 64;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_CAL   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRES_CAL_A = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRES_CAL_B = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRES_CAL_C = 8'd3;

   // queue between front and back
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

   // calibration words as written
   typedef struct packed {
      logic [CAL_W-1:0] temp;
      logic [CAL_W-1:0] pres_a;
      logic [CAL_W-1:0] pres_b;
      logic [CAL_W-1:0] pres_c;
   } bsc_cal_type;

   // temperature results carried with an item
   typedef struct packed {
      logic [FINE_W-1:0]  fine;
      logic [CENTI_W-1:0] centi;
   } bsc_meta_type;

   // one queue entry
   typedef struct packed {
      bsc_meta_type     meta;
      logic [RAW_W-1:0] raw_p;
   } bsc_item_type;

endpackage

>>> rtl/bsc_front.sv
// ----------------------------------------------------------------------------
// bsc_front: temperature front end
// Four-stage pipeline for the 32-bit temperature compensation; finished
// items are pushed into the queue together with the raw pressure.
// ----------------------------------------------------------------------------
module bsc_front import bsc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [CAL_W-1:0] temp_cal,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [RAW_W-1:0] raw_t,
   input  logic [RAW_W-1:0] raw_p,
   input  logic             q_full,
   output logic             push,
   output bsc_item_type     push_item
);

   logic               adv;
   logic [15:0]        t1;
   logic signed [15:0] t2, t3;

   logic vld1_ff, vld2_ff, vld3_ff, vld4_ff;

   logic [31:0]        a_wide, d_wide;
   logic signed [17:0] a_in, a_ff;
   logic signed [16:0] d_in, d_ff;
   logic [RAW_W-1:0]   p1_ff, p2_ff, p3_ff, p4_ff;

   logic signed [33:0] prod_a, prod_d;
   logic [31:0]        v1p_in, v1p_ff, dd_in, dd_ff;

   logic signed [31:0] v1_in, v1_ff, ddsh, m3_in, m3_ff;

   logic signed [31:0] v2, fine_in, c5, centi32;
   logic [FINE_W-1:0]  fine_ff;
   logic [CENTI_W-1:0] centi_ff;

   assign t1  = temp_cal[15:0];
   assign t2  = $signed(temp_cal[31:16]);
   assign t3  = $signed(temp_cal[47:32]);

   // pipeline moves unless the last stage is stuck on a full queue
   assign adv       = !vld4_ff || !q_full;
   assign req_ready = adv;
   assign push      = vld4_ff && !q_full;

   // stage 1: offsets from T1
   assign a_wide = {15'b0, raw_t[19:3]} - {15'b0, t1, 1'b0};
   assign d_wide = {16'b0, raw_t[19:4]} - {16'b0, t1};
   assign a_in   = $signed(a_wide[17:0]);
   assign d_in   = $signed(d_wide[16:0]);

   // stage 2: first products
   assign prod_a = a_ff * t2;
   assign prod_d = d_ff * d_ff;
   assign v1p_in = prod_a[31:0];
   assign dd_in  = prod_d[31:0];

   // stage 3: scale and second product
   assign v1_in = $signed(v1p_ff) >>> 11;
   assign ddsh  = $signed(dd_ff) >>> 12;
   assign m3_in = ddsh * t3;

   // stage 4: fine temperature and hundredths
   assign v2      = m3_ff >>> 14;
   assign fine_in = v1_ff + v2;
   assign c5      = fine_in + (fine_in <<< 2) + 32'sd128;
   assign centi32 = c5 >>> 8;

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= req_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff     <= a_in;
         d_ff     <= d_in;
         p1_ff    <= raw_p;
         v1p_ff   <= v1p_in;
         dd_ff    <= dd_in;
         p2_ff    <= p1_ff;
         v1_ff    <= v1_in;
         m3_ff    <= m3_in;
         p3_ff    <= p2_ff;
         fine_ff  <= fine_in;
         centi_ff <= centi32[CENTI_W-1:0];
         p4_ff    <= p3_ff;
      end
   end

   assign push_item.meta.fine  = fine_ff;
   assign push_item.meta.centi = centi_ff;
   assign push_item.raw_p      = p4_ff;

endmodule

>>> rtl/bsc_queue.sv
// ----------------------------------------------------------------------------
// bsc_queue: item queue
// Small FIFO between the front and back ends so each can stall on its own.
// ----------------------------------------------------------------------------
module bsc_queue import bsc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  bsc_item_type push_item,
   output logic         full,
   input  logic         pop,
   output bsc_item_type head,
   output logic         empty
);

   bsc_item_type        mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_AW:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == QUEUE_DEPTH[QUEUE_AW:0]);
   assign empty = (cnt_ff == '0);
   assign head  = mem[rd_ff];

   // pointer and count update
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_item;
      end
   end

`ifndef ASSERT_OFF
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QUEUE_DEPTH[QUEUE_AW:0])
      else $error("queue count beyond depth");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("pop from empty queue");
   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("queue count missed a transfer");
`endif

endmodule

>>> rtl/bsc_div.sv
// ----------------------------------------------------------------------------
// bsc_div: pipelined signed divider
// 64-bit signed division truncating toward zero, one quotient bit per
// stage, with magnitude and sign stages around it. Flags a zero divisor.
// ----------------------------------------------------------------------------
module bsc_div import bsc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [WIDE_W-1:0] num,
   input  logic [WIDE_W-1:0] den,
   input  bsc_meta_type      in_meta,
   output logic              out_valid,
   output logic [WIDE_W-1:0] quot,
   output logic              out_zero,
   output bsc_meta_type      out_meta
);

   logic              val_ff  [WIDE_W+1];
   logic [WIDE_W-1:0] rem_ff  [WIDE_W+1];
   logic [WIDE_W-1:0] quo_ff  [WIDE_W+1];
   logic [WIDE_W-1:0] dvs_ff  [WIDE_W+1];
   logic              neg_ff  [WIDE_W+1];
   logic              zero_ff [WIDE_W+1];
   bsc_meta_type      meta_ff [WIDE_W+1];

   logic              fv_ff, fz_ff;
   logic [WIDE_W-1:0] fq_ff;
   bsc_meta_type      fm_ff;

   // magnitudes and sign
   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff[0] <= 1'b0;
      end else if (adv) begin
         val_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= '0;
         quo_ff[0]  <= num[WIDE_W-1] ? '0 - num : num;
         dvs_ff[0]  <= den[WIDE_W-1] ? '0 - den : den;
         neg_ff[0]  <= num[WIDE_W-1] ^ den[WIDE_W-1];
         zero_ff[0] <= (den == '0);
         meta_ff[0] <= in_meta;
      end
   end

   // restoring steps, one quotient bit each
   for (genvar k = 0; k < WIDE_W; k++) begin : g_step
      logic [WIDE_W:0]   part;
      logic [WIDE_W:0]   trial;
      logic              ge;

      assign part  = {rem_ff[k], quo_ff[k][WIDE_W-1]};
      assign trial = part - {1'b0, dvs_ff[k]};
      assign ge    = !trial[WIDE_W];

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[k+1] <= 1'b0;
         end else if (adv) begin
            val_ff[k+1] <= val_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k+1]  <= ge ? trial[WIDE_W-1:0] : part[WIDE_W-1:0];
            quo_ff[k+1]  <= {quo_ff[k][WIDE_W-2:0], ge};
            dvs_ff[k+1]  <= dvs_ff[k];
            neg_ff[k+1]  <= neg_ff[k];
            zero_ff[k+1] <= zero_ff[k];
            meta_ff[k+1] <= meta_ff[k];
         end
      end
   end

   // sign of the quotient
   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
      end else if (adv) begin
         fv_ff <= val_ff[WIDE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fq_ff <= neg_ff[WIDE_W] ? '0 - quo_ff[WIDE_W] : quo_ff[WIDE_W];
         fz_ff <= zero_ff[WIDE_W];
         fm_ff <= meta_ff[WIDE_W];
      end
   end

   assign out_valid = fv_ff;
   assign quot      = fq_ff;
   assign out_zero  = fz_ff;
   assign out_meta  = fm_ff;

endmodule

>>> rtl/bsc_back.sv
// ----------------------------------------------------------------------------
// bsc_back: pressure back end
// Pops items from the queue and runs the 64-bit pressure compensation:
// divisor and dividend stages, the divider, correction terms, saturation
// and the result register.
// ----------------------------------------------------------------------------
module bsc_back import bsc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  bsc_cal_type               cal,
   input  logic                      q_empty,
   input  bsc_item_type              q_head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [CENTI_W-1:0] rsp_temperature_centi_c,
   output logic signed [FINE_W-1:0]  rsp_fine_temperature,
   output logic [PRES_W-1:0]         rsp_pressure_q24_8,
   output logic                      rsp_pressure_invalid
);

   logic adv;

   logic [15:0]        p1;
   logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

   // front stage valids
   logic s1_ff, s2_ff, s3_ff, s4_ff, s5_ff, s6_ff;
   bsc_meta_type m1_ff, m2_ff, m3_ff, m4_ff, m5_ff, m6_ff;

   logic signed [32:0] w1_in, w1_ff;
   logic [20:0]        pd_in, pd1_ff, pd2_ff, pd3_ff, pd4_ff;

   logic signed [65:0] ww_full;
   logic signed [48:0] w1p5_in, w1p2_in, w1p5_ff, w1p2_ff, w1p5b_ff, w1p2b_ff;
   logic [63:0]        ww_ff;

   logic signed [63:0] w2a_in, w3a_in;
   logic [63:0]        w2a_ff, w3a_ff;

   logic [63:0] w1p5x, w1p2x, p4x, w3sh, w2_in, w1b_in, w2_ff, w1b_ff;
   logic [63:0] kp_in, nn_in, kp_ff, nn_ff;
   logic [63:0] den_in, num_in, den_ff, num_ff;

   // divider outputs
   logic              dv_valid, dv_zero;
   logic [63:0]       dv_q;
   bsc_meta_type      dv_meta;

   // tail stages
   logic t1_ff, t2_ff, t3_ff, t4_ff;
   logic z1_ff, z2_ff, z3_ff, z4_ff;
   bsc_meta_type tm1_ff, tm2_ff, tm3_ff, tm4_ff;

   logic [63:0]        ps, ll_in, ll_ff, q1_ff, q2_ff, q3_ff;
   logic [31:0]        lh_in, lh_ff;
   logic signed [63:0] p8p_in, x1p_in;
   logic [63:0]        p8p_ff, sq_in, sq_ff, x2_in, x2_ff, x2b_ff, x1p_ff;
   logic [63:0]        x1, tsum, tsh, p7x, res_in, res_ff;

   logic [PRES_W-1:0]  sat;

   logic               o_valid_ff;
   logic [CENTI_W-1:0] o_centi_ff;
   logic [FINE_W-1:0]  o_fine_ff;
   logic [PRES_W-1:0]  o_pres_ff;
   logic               o_inv_ff;

   assign p1 = cal.pres_a[15:0];
   assign p2 = $signed(cal.pres_a[31:16]);
   assign p3 = $signed(cal.pres_a[47:32]);
   assign p4 = $signed(cal.pres_b[15:0]);
   assign p5 = $signed(cal.pres_b[31:16]);
   assign p6 = $signed(cal.pres_b[47:32]);
   assign p7 = $signed(cal.pres_c[15:0]);
   assign p8 = $signed(cal.pres_c[31:16]);
   assign p9 = $signed(cal.pres_c[47:32]);

   // whole back end advances when the result register can take a transfer
   assign adv = !o_valid_ff || rsp_ready;
   assign pop = adv && !q_empty;

   // stage 1: offset fine temperature, pressure complement
   assign w1_in = $signed({q_head.meta.fine[31], q_head.meta.fine}) - 33'sd128000;
   assign pd_in = 21'd1048576 - {1'b0, q_head.raw_p};

   // stage 2: square and linear products
   assign ww_full = w1_ff * w1_ff;
   assign w1p5_in = w1_ff * p5;
   assign w1p2_in = w1_ff * p2;

   // stage 3: products with P6 and P3
   assign w2a_in = $signed(ww_ff) * p6;
   assign w3a_in = $signed(ww_ff) * p3;

   // stage 4: sums
   assign w1p5x  = {{15{w1p5b_ff[48]}}, w1p5b_ff};
   assign w1p2x  = {{15{w1p2b_ff[48]}}, w1p2b_ff};
   assign p4x    = {{48{p4[15]}}, p4};
   assign w2_in  = w2a_ff + (w1p5x << 17) + (p4x << 35);
   assign w3sh   = $signed(w3a_ff) >>> 8;
   assign w1b_in = w3sh + (w1p2x << 12);

   // stage 5: P1 scaling, dividend base
   assign kp_in = (64'h0000_8000_0000_0000 + w1b_ff) * {48'b0, p1};
   assign nn_in = {12'b0, pd4_ff, 31'b0} - w2_ff;

   // stage 6: divisor and dividend
   assign den_in = $signed(kp_ff) >>> 33;
   assign num_in = nn_ff * 64'd3125;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
         s3_ff <= 1'b0;
         s4_ff <= 1'b0;
         s5_ff <= 1'b0;
         s6_ff <= 1'b0;
      end else if (adv) begin
         s1_ff <= !q_empty;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
         s4_ff <= s3_ff;
         s5_ff <= s4_ff;
         s6_ff <= s5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         w1_ff    <= w1_in;
         pd1_ff   <= pd_in;
         m1_ff    <= q_head.meta;
         ww_ff    <= ww_full[63:0];
         w1p5_ff  <= w1p5_in;
         w1p2_ff  <= w1p2_in;
         pd2_ff   <= pd1_ff;
         m2_ff    <= m1_ff;
         w2a_ff   <= w2a_in;
         w3a_ff   <= w3a_in;
         w1p5b_ff <= w1p5_ff;
         w1p2b_ff <= w1p2_ff;
         pd3_ff   <= pd2_ff;
         m3_ff    <= m2_ff;
         w2_ff    <= w2_in;
         w1b_ff   <= w1b_in;
         pd4_ff   <= pd3_ff;
         m4_ff    <= m3_ff;
         kp_ff    <= kp_in;
         nn_ff    <= nn_in;
         m5_ff    <= m4_ff;
         den_ff   <= den_in;
         num_ff   <= num_in;
         m6_ff    <= m5_ff;
      end
   end

   bsc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s6_ff),
      .num       (num_ff),
      .den       (den_ff),
      .in_meta   (m6_ff),
      .out_valid (dv_valid),
      .quot      (dv_q),
      .out_zero  (dv_zero),
      .out_meta  (dv_meta)
   );

   // tail 1: square of the scaled quotient split in 32-bit halves, P8 term
   assign ps     = $signed(dv_q) >>> 13;
   assign ll_in  = {32'b0, ps[31:0]} * {32'b0, ps[31:0]};
   assign lh_in  = ps[31:0] * ps[63:32];
   assign p8p_in = $signed(dv_q) * p8;

   // tail 2: assemble square, shift P8 term
   assign sq_in = ll_ff + {lh_ff[30:0], 1'b0, 32'b0};
   assign x2_in = $signed(p8p_ff) >>> 19;

   // tail 3: P9 term
   assign x1p_in = $signed(sq_ff) * p9;

   // tail 4: final sum
   assign x1     = $signed(x1p_ff) >>> 25;
   assign tsum   = q3_ff + x1 + x2b_ff;
   assign tsh    = $signed(tsum) >>> 8;
   assign p7x    = {{48{p7[15]}}, p7};
   assign res_in = tsh + (p7x << 4);

   // saturation to 32 bits, zero on an invalid divisor
   always_comb begin
      priority if (z4_ff || res_ff[63]) begin
         sat = '0;
      end else if (res_ff[63:32] != '0) begin
         sat = '1;
      end else begin
         sat = res_ff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff <= 1'b0;
         t2_ff <= 1'b0;
         t3_ff <= 1'b0;
         t4_ff <= 1'b0;
      end else if (adv) begin
         t1_ff <= dv_valid;
         t2_ff <= t1_ff;
         t3_ff <= t2_ff;
         t4_ff <= t3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ll_ff  <= ll_in;
         lh_ff  <= lh_in;
         p8p_ff <= p8p_in;
         q1_ff  <= dv_q;
         z1_ff  <= dv_zero;
         tm1_ff <= dv_meta;
         sq_ff  <= sq_in;
         x2_ff  <= x2_in;
         q2_ff  <= q1_ff;
         z2_ff  <= z1_ff;
         tm2_ff <= tm1_ff;
         x1p_ff <= x1p_in;
         x2b_ff <= x2_ff;
         q3_ff  <= q2_ff;
         z3_ff  <= z2_ff;
         tm3_ff <= tm2_ff;
         res_ff <= res_in;
         z4_ff  <= z3_ff;
         tm4_ff <= tm3_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (adv) begin
         o_valid_ff <= t4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_centi_ff <= tm4_ff.centi;
         o_fine_ff  <= tm4_ff.fine;
         o_pres_ff  <= sat;
         o_inv_ff   <= z4_ff;
      end
   end

   assign rsp_valid               = o_valid_ff;
   assign rsp_temperature_centi_c = $signed(o_centi_ff);
   assign rsp_fine_temperature    = $signed(o_fine_ff);
   assign rsp_pressure_q24_8      = o_pres_ff;
   assign rsp_pressure_invalid    = o_inv_ff;

endmodule

>>> rtl/barometric_sensor_compensation.sv
// ----------------------------------------------------------------------------
// barometric_sensor_compensation: integer temperature and pressure
// compensation for a barometric sensor
// ----------------------------------------------------------------------------
// Takes one raw temperature and raw pressure pair per transfer and returns
// one result: temperature in 0.01 degC, fine temperature and pressure in Pa
// as unsigned Q24.8 (saturated, flagged invalid on a zero divisor). One pair
// is accepted every cycle while the queue is not full; most of the pipeline
// depth lies in the divider in the pressure path, with its 64 restoring
// steps. A four-entry queue sits between the temperature front end and the
// pressure back end. Calibration registers are written through the csr_
// port, index 0 to 3; other indexes are ignored. Write them only while no
// item is in flight.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation import bsc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [RAW_W-1:0]          req_raw_temperature,
   input  logic [RAW_W-1:0]          req_raw_pressure,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [CENTI_W-1:0] rsp_temperature_centi_c,
   output logic signed [FINE_W-1:0]  rsp_fine_temperature,
   output logic [PRES_W-1:0]         rsp_pressure_q24_8,
   output logic                      rsp_pressure_invalid,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CAL_W-1:0]          csr_data
);

   bsc_cal_type  cal_ff;
   logic         q_push, q_pop, q_full, q_empty;
   bsc_item_type q_in, q_head;

   assign csr_ready = 1'b1;

   // calibration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TEMP_CAL:   cal_ff.temp   <= csr_data;
            CSR_PRES_CAL_A: cal_ff.pres_a <= csr_data;
            CSR_PRES_CAL_B: cal_ff.pres_b <= csr_data;
            CSR_PRES_CAL_C: cal_ff.pres_c <= csr_data;
            default: ;
         endcase
      end
   end

   bsc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .temp_cal  (cal_ff.temp),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .raw_t     (req_raw_temperature),
      .raw_p     (req_raw_pressure),
      .q_full    (q_full),
      .push      (q_push),
      .push_item (q_in)
   );

   bsc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   bsc_back u_back (
      .clock                   (clock),
      .reset                   (reset),
      .cal                     (cal_ff),
      .q_empty                 (q_empty),
      .q_head                  (q_head),
      .pop                     (q_pop),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_temperature_centi_c (rsp_temperature_centi_c),
      .rsp_fine_temperature    (rsp_fine_temperature),
      .rsp_pressure_q24_8      (rsp_pressure_q24_8),
      .rsp_pressure_invalid    (rsp_pressure_invalid)
   );

endmodule

>>> sim/tb_barometric_sensor_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_barometric_sensor_compensation: self-checking bench for the compensation
// Drives raw temperature and pressure pairs with random gaps, predicts each
// result from the calibration words in 32/64-bit wrapping arithmetic and
// compares every returned transfer field by field in order.
// ----------------------------------------------------------------------------
module tb_barometric_sensor_compensation;
   import bsc_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 120;

   typedef struct packed {
      logic signed [CENTI_W-1:0] centi;
      logic signed [FINE_W-1:0]  fine;
      logic [PRES_W-1:0]         pres;
      logic                      invalid;
   } comp_result_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [RAW_W-1:0]          req_raw_temperature;
   logic [RAW_W-1:0]          req_raw_pressure;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [CENTI_W-1:0] rsp_temperature_centi_c;
   logic signed [FINE_W-1:0]  rsp_fine_temperature;
   logic [PRES_W-1:0]         rsp_pressure_q24_8;
   logic                      rsp_pressure_invalid;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CAL_W-1:0]          csr_data;

   // shadow calibration words
   logic [CAL_W-1:0] cal_temp, cal_a, cal_b, cal_c;

   comp_result_type expected_results[$];
   int  mismatch_count;
   int  idle_cycles;
   bit  rsp_stall_enable;

   barometric_sensor_compensation u_dut (.*);

   always #10 clock = ~clock;

   // signed 16-bit field widened to 64 bits
   function automatic logic signed [63:0] cal_field(logic [CAL_W-1:0] w, int pos);
      logic signed [15:0] f;
      f = w[pos +: 16];
      return 64'(f);
   endfunction

   function automatic logic signed [63:0] div_trunc(logic signed [63:0] a,
                                                    logic signed [63:0] b);
      logic [63:0] ma, mb, q;
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      q = ma / mb;
      return (a[63] != b[63]) ? -q : q;
   endfunction

   function automatic comp_result_type compensate(logic [RAW_W-1:0] raw_t,
                                                  logic [RAW_W-1:0] raw_p);
      comp_result_type r;
      logic signed [31:0] t1, t2, t3, a, v1, d, v2, fine;
      logic signed [63:0] p1, w1, w2, p, ps, x1, x2;
      t1 = {16'd0, cal_temp[15:0]};
      t2 = 32'(cal_field(cal_temp, 16));
      t3 = 32'(cal_field(cal_temp, 32));
      a = 32'(raw_t >> 3) - (t1 << 1);
      v1 = (a * t2) >>> 11;
      d = 32'(raw_t >> 4) - t1;
      v2 = (((d * d) >>> 12) * t3) >>> 14;
      fine = v1 + v2;
      r.fine = fine;
      r.centi = 24'((fine * 5 + 128) >>> 8);
      p1 = {48'd0, cal_a[15:0]};
      w1 = 64'(fine) - 128000;
      w2 = w1 * w1 * cal_field(cal_b, 32);
      w2 = w2 + ((w1 * cal_field(cal_b, 16)) << 17);
      w2 = w2 + (cal_field(cal_b, 0) << 35);
      w1 = ((w1 * w1 * cal_field(cal_a, 32)) >>> 8) + ((w1 * cal_field(cal_a, 16)) << 12);
      w1 = (((64'sd1 << 47) + w1) * p1) >>> 33;
      r.pres = '0;
      r.invalid = 1'b0;
      if (w1 == 0) begin
         r.invalid = 1'b1;
      end else begin
         p = 64'sd1048576 - 64'(raw_p);
         p = div_trunc(((p << 31) - w2) * 3125, w1);
         ps = p >>> 13;
         x1 = (cal_field(cal_c, 32) * ps * ps) >>> 25;
         x2 = (cal_field(cal_c, 16) * p) >>> 19;
         p = ((p + x1 + x2) >>> 8) + (cal_field(cal_c, 0) << 4);
         if (p < 0)
            r.pres = '0;
         else if (p > 64'sh0FFFF_FFFF)
            r.pres = '1;
         else
            r.pres = p[31:0];
      end
      return r;
   endfunction

   // no gap half the time, otherwise mostly short gaps and a few long ones
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_pair(logic [RAW_W-1:0] raw_t, logic [RAW_W-1:0] raw_p, bit gaps);
      int gap;
      gap = gaps ? gap_length() : 0;
      repeat (gap) @(negedge clock);
      req_valid = 1'b1;
      req_raw_temperature <= raw_t;
      req_raw_pressure <= raw_p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_results.push_back(compensate(raw_t, raw_p));
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_cal(logic [CSR_IDX_W-1:0] idx, logic [CAL_W-1:0] value);
      csr_valid = 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_TEMP_CAL:   cal_temp = value;
         CSR_PRES_CAL_A: cal_a = value;
         CSR_PRES_CAL_B: cal_b = value;
         CSR_PRES_CAL_C: cal_c = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic load_cal(logic [CAL_W-1:0] t, logic [CAL_W-1:0] a,
                           logic [CAL_W-1:0] b, logic [CAL_W-1:0] c);
      wait_drained();
      write_cal(CSR_TEMP_CAL, t);
      write_cal(CSR_PRES_CAL_A, a);
      write_cal(CSR_PRES_CAL_B, b);
      write_cal(CSR_PRES_CAL_C, c);
   endtask

   function automatic logic [CAL_W-1:0] rand_cal();
      return 48'({$urandom(), $urandom()});
   endfunction

   // typical calibration words with small random offsets
   function automatic logic [CAL_W-1:0] jitter(logic [15:0] f2, logic [15:0] f1,
                                               logic [15:0] f0);
      return {f2 + 16'($urandom_range(0, 15)), f1 + 16'($urandom_range(0, 15)),
              f0 + 16'($urandom_range(0, 15))};
   endfunction

   // reset calibration: every divisor is zero
   task automatic test_reset_cal();
      send_pair('0, '0, 0);
      send_pair('1, '1, 0);
      send_pair(20'h5A5A5, 20'hA5A5A, 0);
   endtask

   // extremes of the raw fields and of the calibration words
   task automatic test_directed();
      logic [RAW_W-1:0] corners[4];
      corners = '{20'h00000, 20'hFFFFF, 20'h80000, 20'h7FFFF};
      load_cal({16'hFC18, 16'h6A2C, 16'h6EA0}, {16'h0BB8, 16'hD6D0, 16'h8E80},
               {16'hFFF9, 16'h008C, 16'h2B00}, {16'h1770, 16'hC4F0, 16'h000F});
      foreach (corners[i])
         foreach (corners[j])
            send_pair(corners[i], corners[j], 0);
      send_pair(20'd519888, 20'd415148, 0);
      // invalid write index is ignored
      wait_drained();
      write_cal(8'hFF, '1);
      send_pair(20'd519888, 20'd415148, 0);
      load_cal('1, '1, '1, '1);
      send_pair('0, '0, 0);
      send_pair('1, '1, 0);
      load_cal({16'h8000, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h8000, 16'hFFFF},
               {16'h8000, 16'h7FFF, 16'h8000}, {16'h7FFF, 16'h8000, 16'h7FFF});
      send_pair('0, '1, 0);
      send_pair('1, '0, 0);
   endtask

   // random pairs, mostly on realistic calibration, some on noise
   task automatic test_random(int count);
      for (int n = 0; n < count; n++) begin
         if (n % 150 == 0) begin
            if ($urandom_range(0, 2) == 0)
               load_cal(rand_cal(), rand_cal(), rand_cal(), rand_cal());
            else
               load_cal(jitter(16'hFC18, 16'h6A2C, 16'h6EA0),
                        jitter(16'h0BB8, 16'hD6D0, 16'h8E80),
                        jitter(16'hFFF9, 16'h008C, 16'h2B00),
                        jitter(16'h1770, 16'hC4F0, 16'h000F));
         end
         if (n == count / 2) wait_drained();
         send_pair(20'($urandom()), 20'($urandom()), 1);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      comp_result_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_temperature_centi_c, rsp_fine_temperature,
                 rsp_pressure_q24_8, rsp_pressure_invalid};
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result transfer: %p", got);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   // result-side stalls
   always @(negedge clock) begin
      int stall;
      if (rsp_stall_enable && $urandom_range(0, 3) == 0) begin
         stall = gap_length();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
      rsp_ready <= 1'b1;
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_raw_temperature = '0;
      req_raw_pressure = '0;
      rsp_ready = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      cal_temp = '0;
      cal_a = '0;
      cal_b = '0;
      cal_c = '0;
      mismatch_count = 0;
      idle_cycles = 0;
      rsp_stall_enable = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_cal();
      test_directed();
      rsp_stall_enable = 1'b1;
      test_random(1620);
      wait_drained();
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
